[rtl/msfr_pkg.sv]
package msfr_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int POS_W = 6;
	localparam int HEADER_BYTES = 5;
	localparam int LEN_OVERHEAD = 6;
	localparam int STORE_FIRST = 3;
	localparam int STORE_LAST = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] STATUS_LEN = 8'd18;
	localparam logic [7:0] OWN_ADDR_RST = 8'd184;
	localparam logic [7:0] CTRL_ADDR_RST = 8'd183;
	localparam logic [7:0] MOTOR_NUM_RST = 8'd1;

	typedef enum logic [2:0] {
		EV_IGNORED = 3'd0,
		EV_STORED  = 3'd1,
		EV_HDR_ERR = 3'd2,
		EV_CK_ERR  = 3'd3,
		EV_GOOD    = 3'd4,
		EV_STATUS  = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN   = 2'd0,
		CFG_CTRL  = 2'd1,
		CFG_MOTOR = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]         pid;
		logic signed [15:0] left_speed;
		logic [15:0]        left_amps;
		logic [7:0]         left_status;
		logic signed [31:0] left_pos;
		logic signed [15:0] right_speed;
		logic [15:0]        right_amps;
		logic [7:0]         right_status;
		logic signed [31:0] right_pos;
	} status_t;

	typedef struct packed {
		event_t      event_code;
		status_t     status;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} result_t;

endpackage

[rtl/msfr_if.sv]
interface msfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface msfr_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_code;
	logic [7:0]         frame_pid;
	logic signed [15:0] left_speed;
	logic [15:0]        left_amps;
	logic [7:0]         left_status;
	logic signed [31:0] left_pos;
	logic signed [15:0] right_speed;
	logic [15:0]        right_amps;
	logic [7:0]         right_status;
	logic signed [31:0] right_pos;
	logic [31:0]        good_frames;
	logic [31:0]        bad_frames;

	modport source (output valid, output event_code, output frame_pid, output left_speed,
		output left_amps, output left_status, output left_pos, output right_speed,
		output right_amps, output right_status, output right_pos, output good_frames,
		output bad_frames, input ready);
	modport sink (input valid, input event_code, input frame_pid, input left_speed,
		input left_amps, input left_status, input left_pos, input right_speed,
		input right_amps, input right_status, input right_pos, input good_frames,
		input bad_frames, output ready);
endinterface

[rtl/motor_status_frame_receiver_top.sv]
// Channel   Dir  Payload                                        Handshake
// rx        in   rx_byte[7:0]                                   valid/ready
// res       out  event_code, status fields, frame counters      valid/ready
// cfg       in   cfg_index[1:0], cfg_data[7:0]                  cfg_we, no stall
//
// One byte per cycle while res is not stalled: input register, one pass of frame logic, result register.
// An rx byte is held in the input register, then its result in the result register, then it transfers on res.
// A new byte is taken while a result waits, as long as the input register is empty
// or can move on.
// arst_n clears frame position, checksum, status record and counters.
module motor_status_frame_receiver_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [msfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data,
	msfr_in_if.sink                          rx,
	msfr_out_if.source                       res
);

	logic [7:0] own_q, ctrl_q, motor_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic                 out_valid_s2;
	msfr_pkg::result_t    out_s2;

	logic [msfr_pkg::POS_W-1:0] pos_q, exp_q;
	logic [7:0]                 sum_q;
	logic                       len18_q;
	msfr_pkg::status_t          stat_q;
	logic [31:0]                good_q, bad_q;
	logic [7:0]                 frame_q [msfr_pkg::STORE_FIRST:msfr_pkg::STORE_LAST];

	logic advance;

	logic [msfr_pkg::POS_W-1:0] pos_d, exp_d, npos, exp_cur;
	logic [7:0]                 sum_d, nsum;
	logic                       len18_d, store_en, hdr_bad;
	msfr_pkg::status_t          stat_d, stat_frame;
	logic [31:0]                good_d, bad_d;
	msfr_pkg::event_t           ev;

	assign advance = valid_s1 && (!out_valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= msfr_pkg::OWN_ADDR_RST;
			ctrl_q <= msfr_pkg::CTRL_ADDR_RST;
			motor_q <= msfr_pkg::MOTOR_NUM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msfr_pkg::CFG_OWN: own_q <= cfg_data;
				msfr_pkg::CFG_CTRL: ctrl_q <= cfg_data;
				msfr_pkg::CFG_MOTOR: motor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stat_frame.pid = frame_q[3];
	assign stat_frame.left_speed = {frame_q[6], frame_q[5]};
	assign stat_frame.left_amps = {frame_q[8], frame_q[7]};
	assign stat_frame.left_status = frame_q[9];
	assign stat_frame.left_pos = {frame_q[13], frame_q[12], frame_q[11], frame_q[10]};
	assign stat_frame.right_speed = {frame_q[15], frame_q[14]};
	assign stat_frame.right_amps = {frame_q[17], frame_q[16]};
	assign stat_frame.right_status = frame_q[18];
	assign stat_frame.right_pos = {frame_q[22], frame_q[21], frame_q[20], frame_q[19]};

	assign npos = pos_q + 1'b1;
	assign nsum = sum_q + byte_s1;
	assign exp_cur = (npos == msfr_pkg::POS_W'(msfr_pkg::HEADER_BYTES)) ?
		byte_s1[msfr_pkg::POS_W-1:0] + msfr_pkg::POS_W'(msfr_pkg::LEN_OVERHEAD) : exp_q;
	assign hdr_bad = (npos == msfr_pkg::POS_W'(2) && byte_s1 != ctrl_q) ||
		(npos == msfr_pkg::POS_W'(3) && byte_s1 != motor_q) ||
		(npos == msfr_pkg::POS_W'(msfr_pkg::HEADER_BYTES) &&
		byte_s1 > 8'(msfr_pkg::MAX_FRAME_BYTES - msfr_pkg::LEN_OVERHEAD));

	always_comb begin
		ev = msfr_pkg::EV_IGNORED;
		pos_d = pos_q;
		exp_d = exp_q;
		sum_d = sum_q;
		len18_d = len18_q;
		stat_d = stat_q;
		good_d = good_q;
		bad_d = bad_q;
		store_en = 1'b0;
		if (pos_q == '0 && byte_s1 != own_q) begin
			ev = msfr_pkg::EV_IGNORED;
		end else if (pos_q >= msfr_pkg::POS_W'(msfr_pkg::MAX_FRAME_BYTES)) begin
			ev = msfr_pkg::EV_HDR_ERR;
			pos_d = '0;
			exp_d = '0;
			sum_d = '0;
			bad_d = bad_q + 32'd1;
		end else begin
			store_en = 1'b1;
			if (hdr_bad) begin
				ev = msfr_pkg::EV_HDR_ERR;
				pos_d = '0;
				exp_d = '0;
				sum_d = '0;
				bad_d = bad_q + 32'd1;
			end else if (exp_cur != '0 && npos >= exp_cur) begin
				pos_d = '0;
				exp_d = '0;
				sum_d = '0;
				if (nsum == 8'd0) begin
					good_d = good_q + 32'd1;
					if (len18_q) begin
						stat_d = stat_frame;
						ev = msfr_pkg::EV_STATUS;
					end else begin
						ev = msfr_pkg::EV_GOOD;
					end
				end else begin
					bad_d = bad_q + 32'd1;
					ev = msfr_pkg::EV_CK_ERR;
				end
			end else begin
				ev = msfr_pkg::EV_STORED;
				pos_d = npos;
				exp_d = exp_cur;
				sum_d = nsum;
				if (npos == msfr_pkg::POS_W'(msfr_pkg::HEADER_BYTES)) begin
					len18_d = (byte_s1 == msfr_pkg::STATUS_LEN);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			exp_q <= '0;
			sum_q <= '0;
			len18_q <= 1'b0;
			stat_q <= '0;
			good_q <= '0;
			bad_q <= '0;
		end else if (advance) begin
			pos_q <= pos_d;
			exp_q <= exp_d;
			sum_q <= sum_d;
			len18_q <= len18_d;
			stat_q <= stat_d;
			good_q <= good_d;
			bad_q <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_en) begin
			for (int i = msfr_pkg::STORE_FIRST; i <= msfr_pkg::STORE_LAST; i++) begin
				if (pos_q == msfr_pkg::POS_W'(i)) begin
					frame_q[i] <= byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2.event_code <= ev;
			out_s2.status <= stat_d;
			out_s2.good_frames <= good_d;
			out_s2.bad_frames <= bad_d;
		end
	end

	assign res.valid = out_valid_s2;
	assign res.event_code = out_s2.event_code;
	assign res.frame_pid = out_s2.status.pid;
	assign res.left_speed = out_s2.status.left_speed;
	assign res.left_amps = out_s2.status.left_amps;
	assign res.left_status = out_s2.status.left_status;
	assign res.left_pos = out_s2.status.left_pos;
	assign res.right_speed = out_s2.status.right_speed;
	assign res.right_amps = out_s2.status.right_amps;
	assign res.right_status = out_s2.status.right_status;
	assign res.right_pos = out_s2.status.right_pos;
	assign res.good_frames = out_s2.good_frames;
	assign res.bad_frames = out_s2.bad_frames;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < msfr_pkg::POS_W'(msfr_pkg::MAX_FRAME_BYTES))
		else $error("frame position past maximum");

	a_good_event: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(good_q) |-> out_valid_s2 &&
		(out_s2.event_code == msfr_pkg::EV_GOOD || out_s2.event_code == msfr_pkg::EV_STATUS))
		else $error("good count moved without a good frame event");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_s2 && !res.ready |-> !rx.ready)
		else $error("input taken while both stages are full and stalled");

endmodule
